// ===== design/pdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_pkg: shared types, constants and helpers
// Holds the queue entry, the configuration bundle, opcodes and axis helpers.
// ----------------------------------------------------------------------------
package pdh_pkg;

    localparam int DH_MAX_BINS = 64;
    localparam int SPECIES     = 5;
    localparam int Q_DEPTH     = 2;

    // Opcodes carried in the input request.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Distance modes.
    localparam logic [1:0] MODE_NORM = 2'd0;
    localparam logic [1:0] MODE_X    = 2'd1;
    localparam logic [1:0] MODE_Y    = 2'd2;
    localparam logic [1:0] MODE_Z    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_BOX_LENGTH     = 3'd0;
    localparam logic [2:0] REG_BIN_WIDTH      = 3'd1;
    localparam logic [2:0] REG_BINS_IN_USE    = 3'd2;
    localparam logic [2:0] REG_DISTANCE_MODE  = 3'd3;
    localparam logic [2:0] REG_FAST_THRESHOLD = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [2:0]  species;
        logic [2:0]  sel_species;
        logic [5:0]  sel_bin;
    } pdh_entry_t;

    typedef struct packed {
        logic [30:0] bin_width;
        logic [6:0]  bins_in_use;
        logic [1:0]  distance_mode;
        logic [30:0] fast_threshold;
    } pdh_cfg_t;

    function automatic logic [2:0] species_of(input logic [7:0] charge);
        logic [2:0] sp;
        if (charge < 8'd3) begin
            sp = 3'd0;
        end else if (charge < 8'd7) begin
            sp = 3'd1;
        end else if (charge < 8'd9) begin
            sp = 3'd2;
        end else if (charge < 8'd11) begin
            sp = 3'd3;
        end else begin
            sp = 3'd4;
        end
        return sp;
    endfunction

    function automatic logic [33:0] abs34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    // Minimum-image distance along one axis.
    function automatic logic [31:0] axis_dist(input logic [31:0] o, input logic [31:0] n,
                                              input logic [30:0] len);
        logic signed [33:0] d;
        logic signed [33:0] l;
        logic [33:0] a;
        logic [33:0] b;
        logic [33:0] c;
        d = 34'(signed'(n)) - 34'(signed'(o));
        l = signed'({3'b000, len});
        a = abs34(d);
        b = abs34(d - l);
        c = abs34(d + l);
        if (b < a) begin
            a = b;
        end
        if (c < a) begin
            a = c;
        end
        return a[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/pdh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 320
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== design/pdh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_front: request intake and classification
// Computes minimum-image axis distances and the species, then queues the work.
// ----------------------------------------------------------------------------
module pdh_front
    import pdh_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [215:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic [30:0] box_length,
    input  wire logic        q_full,
    input  wire logic        init_done,
    output logic             q_push,
    output pdh_entry_t       q_entry
);
    assign s_tready = !q_full && init_done;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_entry.opcode      = s_tuser;
        q_entry.ax          = axis_dist(s_tdata[31:0],  s_tdata[127:96],  box_length);
        q_entry.ay          = axis_dist(s_tdata[63:32], s_tdata[159:128], box_length);
        q_entry.az          = axis_dist(s_tdata[95:64], s_tdata[191:160], box_length);
        q_entry.species     = species_of(s_tdata[199:192]);
        q_entry.sel_species = s_tdata[202:200];
        q_entry.sel_bin     = s_tdata[208:203];
    end
endmodule
`default_nettype wire

// ===== design/pdh_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_queue: short queue between intake and execution
// A small FIFO of classified requests.
// ----------------------------------------------------------------------------
module pdh_queue
    import pdh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire pdh_entry_t entry_in,
    input  wire logic       pop,
    output logic            valid,
    output logic            full,
    output pdh_entry_t      entry_out
);
    localparam int PW = $clog2(Q_DEPTH);

    pdh_entry_t         slot_reg [Q_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;

    assign valid     = count_reg != '0;
    assign full      = count_reg == (PW+1)'(Q_DEPTH);
    assign entry_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= entry_in;
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/pdh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_back: execution sequencer
// Squares, sums, square root, bin search, histogram update and result output.
// ----------------------------------------------------------------------------
module pdh_back
    import pdh_pkg::*;
#(
    parameter int MAX_BINS = DH_MAX_BINS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire pdh_cfg_t     cfg,
    input  wire logic         q_valid,
    input  wire pdh_entry_t   q_entry,
    output logic              q_pop,
    output logic              init_done,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    localparam int DEPTH = SPECIES * MAX_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_BINS + 1);
    localparam int EW    = 31 + KW;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_MUL    = 10'b0000000100,
        S_SUM    = 10'b0000001000,
        S_SQRT   = 10'b0000010000,
        S_BINIT  = 10'b0000100000,
        S_SEARCH = 10'b0001000000,
        S_INC    = 10'b0010000000,
        S_BINRD  = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    pdh_entry_t      ent_reg;
    logic [2:0]      step_reg;
    logic [63:0]     prod_reg;
    logic [65:0]     acc_reg;
    logic [63:0]     thr_sq_reg;
    logic [65:0]     rad_reg;
    logic [34:0]     rem_reg;
    logic [32:0]     root_reg;
    logic [5:0]      cnt_reg;
    logic [32:0]     r_reg;
    logic [KW-1:0]   k_reg;
    logic [EW-1:0]   edge_reg;
    logic [AW-1:0]   addr_reg;
    logic [AW-1:0]   clr_reg;
    logic [31:0]     bin_reg;
    logic [2:0]      emit_reg;
    logic [63:0]     cfg_sum_reg [SPECIES];
    logic [63:0]     tot_sum_reg [SPECIES];
    logic            out_valid_reg;
    logic [159:0]    out_data_reg;
    logic [2:0]      out_user_reg;
    logic            out_last_reg;

    logic [KW-1:0]   limit;
    logic [31:0]     mul_op;
    logic [63:0]     sq;
    logic [2:0]      sum_idx;
    logic [63:0]     sum_cfg_rd;
    logic [63:0]     sum_tot_rd;
    logic [64:0]     add_cfg;
    logic [64:0]     add_tot;
    logic [34:0]     rem_shift;
    logic [34:0]     trial;
    logic            sqrt_take;
    logic [32:0]     root_new;
    logic [AW-1:0]   search_addr;
    logic [AW-1:0]   read_addr;
    logic            read_ok;
    logic            head_read_ok;
    logic            sel_ok;
    logic            out_free;
    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [31:0]     ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    logic [31:0]     ram_rd_data;

    assign init_done = state_reg != S_CLEAR;
    assign q_pop     = state_reg == S_IDLE && q_valid;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign m_tlast   = out_last_reg;

    always_comb begin
        if (32'(cfg.bins_in_use) > 32'(MAX_BINS)) begin
            limit = KW'(MAX_BINS);
        end else begin
            limit = KW'(cfg.bins_in_use);
        end
    end

    // Operand for the shared multiplier: threshold first, then each axis.
    always_comb begin
        case (step_reg)
            3'd0: mul_op = {1'b0, cfg.fast_threshold};
            3'd1: mul_op = (cfg.distance_mode == MODE_NORM || cfg.distance_mode == MODE_X)
                           ? ent_reg.ax : '0;
            3'd2: mul_op = (cfg.distance_mode == MODE_NORM || cfg.distance_mode == MODE_Y)
                           ? ent_reg.ay : '0;
            3'd3: mul_op = (cfg.distance_mode == MODE_NORM || cfg.distance_mode == MODE_Z)
                           ? ent_reg.az : '0;
            default: mul_op = '0;
        endcase
    end

    assign sq = (acc_reg[65:64] != 2'b00) ? '1 : acc_reg[63:0];

    assign sel_ok = ent_reg.sel_species < 3'(SPECIES);
    always_comb begin
        if (state_reg == S_EMIT) begin
            if (ent_reg.opcode == OP_END) begin
                sum_idx = emit_reg;
            end else begin
                sum_idx = sel_ok ? ent_reg.sel_species : 3'd0;
            end
        end else begin
            sum_idx = ent_reg.species;
        end
    end
    assign sum_cfg_rd = cfg_sum_reg[sum_idx];
    assign sum_tot_rd = tot_sum_reg[sum_idx];
    assign add_cfg    = 65'(sum_cfg_rd) + 65'(sq);
    assign add_tot    = 65'(sum_tot_rd) + 65'(sq);

    // One result bit of the square root per cycle.
    assign rem_shift = {rem_reg[32:0], rad_reg[65:64]};
    assign trial     = {root_reg, 2'b01};
    assign sqrt_take = rem_shift >= trial;
    assign root_new  = {root_reg[31:0], sqrt_take};

    assign search_addr = AW'(ent_reg.species) * AW'(MAX_BINS) + AW'(k_reg);
    assign head_read_ok = q_entry.sel_species < 3'(SPECIES)
                          && 32'(q_entry.sel_bin) < 32'(MAX_BINS);
    assign read_addr = head_read_ok
                       ? AW'(q_entry.sel_species) * AW'(MAX_BINS) + AW'(q_entry.sel_bin)
                       : '0;
    assign read_ok = sel_ok && 32'(ent_reg.sel_bin) < 32'(MAX_BINS);
    assign ram_rd_addr = (state_reg == S_IDLE) ? read_addr : search_addr;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 32'd1;
        if (state_reg == S_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_reg;
            ram_wr_data = '0;
        end else if (state_reg == S_INC) begin
            ram_wr_en = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (q_valid) begin
                    case (q_entry.opcode)
                        OP_SAMPLE: state_next = S_MUL;
                        OP_END:    state_next = S_EMIT;
                        OP_READ:   state_next = S_BINRD;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:    if (step_reg == 3'd4) state_next = S_SUM;
            S_SUM:    state_next = (cfg.distance_mode == MODE_NORM) ? S_SQRT : S_BINIT;
            S_SQRT:   if (cnt_reg == '0) state_next = S_BINIT;
            S_BINIT:  state_next = (cfg.bin_width == '0 || limit == '0) ? S_IDLE : S_SEARCH;
            S_SEARCH: begin
                if (64'(r_reg) < 64'(edge_reg)) begin
                    state_next = S_INC;
                end else if (k_reg == limit - 1'b1) begin
                    state_next = S_IDLE;
                end
            end
            S_INC:    state_next = S_IDLE;
            S_BINRD:  state_next = S_EMIT;
            S_EMIT: begin
                if (out_free && (ent_reg.opcode != OP_END || emit_reg == 3'(SPECIES - 1))) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SPECIES; i++) begin
                cfg_sum_reg[i] <= '0;
                tot_sum_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // A taken result frees the output register unless a new one loads.
            if (m_tready && !(state_reg == S_EMIT && out_free)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 1'b1;
                S_IDLE: begin
                    if (q_valid) begin
                        ent_reg  <= q_entry;
                        step_reg <= '0;
                        acc_reg  <= '0;
                        emit_reg <= '0;
                        clr_reg  <= '0;
                        if (q_entry.opcode == OP_CLEAR) begin
                            for (int i = 0; i < SPECIES; i++) begin
                                cfg_sum_reg[i] <= '0;
                                tot_sum_reg[i] <= '0;
                            end
                        end
                    end
                end
                S_MUL: begin
                    prod_reg <= 64'(mul_op) * 64'(mul_op);
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd1) begin
                        thr_sq_reg <= prod_reg;
                    end else if (step_reg != 3'd0) begin
                        acc_reg <= acc_reg + 66'(prod_reg);
                    end
                end
                S_SUM: begin
                    if (sq > thr_sq_reg) begin
                        cfg_sum_reg[sum_idx] <= add_cfg[64] ? '1 : add_cfg[63:0];
                        tot_sum_reg[sum_idx] <= add_tot[64] ? '1 : add_tot[63:0];
                    end
                    rad_reg  <= acc_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= 6'd32;
                    case (cfg.distance_mode)
                        MODE_X:  r_reg <= 33'(ent_reg.ax);
                        MODE_Y:  r_reg <= 33'(ent_reg.ay);
                        default: r_reg <= 33'(ent_reg.az);
                    endcase
                end
                S_SQRT: begin
                    rem_reg  <= sqrt_take ? rem_shift - trial : rem_shift;
                    root_reg <= root_new;
                    rad_reg  <= {rad_reg[63:0], 2'b00};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        r_reg <= root_new;
                    end
                end
                S_BINIT: begin
                    k_reg    <= '0;
                    edge_reg <= EW'(cfg.bin_width);
                end
                S_SEARCH: begin
                    addr_reg <= search_addr;
                    k_reg    <= k_reg + 1'b1;
                    edge_reg <= edge_reg + EW'(cfg.bin_width);
                end
                S_BINRD: bin_reg <= read_ok ? ram_rd_data : '0;
                S_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        if (ent_reg.opcode == OP_END) begin
                            out_user_reg <= emit_reg;
                            out_data_reg <= {32'd0, sum_tot_rd, sum_cfg_rd};
                            out_last_reg <= emit_reg == 3'(SPECIES - 1);
                            emit_reg     <= emit_reg + 1'b1;
                            if (emit_reg == 3'(SPECIES - 1)) begin
                                for (int i = 0; i < SPECIES; i++) begin
                                    cfg_sum_reg[i] <= '0;
                                end
                            end
                        end else begin
                            out_user_reg <= ent_reg.sel_species;
                            out_data_reg <= sel_ok ? {bin_reg, sum_tot_rd, sum_cfg_rd} : '0;
                            out_last_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    pdh_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );
endmodule
`default_nettype wire

// ===== design/periodic_displacement_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_displacement_histogram: minimum-image displacement statistics
// Per-species squared-displacement sums and distance histograms.
// ----------------------------------------------------------------------------
// Each request carries an opcode in s_tuser. Once it leaves the queue, a
// sample request passes through the multiply and sum states, in norm mode a
// square root, then a bin search over up to MAX_BINS bins and an update when a
// bin is counted; the bin is found by walking bin edges one per cycle and the
// 3D norm takes a bit-serial square root of 33 steps.
// An end request yields five results, one per species, a read request one.
// After reset, and after every clear request, the histogram memory is swept
// one entry per cycle over all SPECIES * MAX_BINS entries, 320 by default;
// during a sweep no request is taken, though configuration writes are.
// Requests are classified on entry and wait in a two-entry queue, so outside
// a sweep intake keeps going until the queue is full while the execution side
// works or waits on the result port.
module periodic_displacement_histogram
    import pdh_pkg::*;
#(
    parameter int MAX_BINS = DH_MAX_BINS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port.
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [30:0]  cfg_wdata,
    // Input requests.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // old_x, old_y, old_z, new_x, new_y, new_z, ion_charge, species_select,
    // bin_select, then zero fill.
    input  wire logic [215:0] s_tdata,
    // opcode.
    input  wire logic [1:0]   s_tuser,
    // Results.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // config_sum, total_sum, bin_value.
    output logic [159:0]      m_tdata,
    // species.
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    logic [30:0] box_length_reg;
    pdh_cfg_t    cfg_reg;

    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    logic        q_full;
    logic        init_done;
    pdh_entry_t  q_in;
    pdh_entry_t  q_out;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_length_reg         <= 31'd1048576;
            cfg_reg.bin_width      <= 31'd16384;
            cfg_reg.bins_in_use    <= 7'd64;
            cfg_reg.distance_mode  <= MODE_NORM;
            cfg_reg.fast_threshold <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BOX_LENGTH:     box_length_reg         <= cfg_wdata;
                REG_BIN_WIDTH:      cfg_reg.bin_width      <= cfg_wdata;
                REG_BINS_IN_USE:    cfg_reg.bins_in_use    <= cfg_wdata[6:0];
                REG_DISTANCE_MODE:  cfg_reg.distance_mode  <= cfg_wdata[1:0];
                REG_FAST_THRESHOLD: cfg_reg.fast_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pdh_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .box_length (box_length_reg),
        .q_full     (q_full),
        .init_done  (init_done),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    pdh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .entry_in  (q_in),
        .pop       (q_pop),
        .valid     (q_valid),
        .full      (q_full),
        .entry_out (q_out)
    );

    pdh_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire
